/* hw/rtl/bwtb_pkg.sv */
// Shared types, constants and the control program of the in-place BWT builder.
`default_nettype none

package bwtb_pkg;

   // Store geometry and field widths
   localparam int MAX_LEN = 4096;
   localparam int ADDR_W  = 12;
   localparam int LEN_W   = 13;
   localparam int SYM_W   = 8;
   localparam int PC_W    = 4;

   // Request kinds (carried in tuser)
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef logic [PC_W-1:0] pc_type;

   // Program step addresses
   localparam pc_type STEP_IDLE       = 4'd0;
   localparam pc_type STEP_DISPATCH   = 4'd1;
   localparam pc_type STEP_SEAL       = 4'd2;
   localparam pc_type STEP_FETCH      = 4'd3;
   localparam pc_type STEP_SCAN_SETUP = 4'd4;
   localparam pc_type STEP_SCAN       = 4'd5;
   localparam pc_type STEP_PUT_C      = 4'd6;
   localparam pc_type STEP_SHIFT      = 4'd7;
   localparam pc_type STEP_PUT_SENT   = 4'd8;
   localparam pc_type STEP_FINISH     = 4'd9;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_ACCEPT,
      OP_DISPATCH,
      OP_SEAL,
      OP_FETCH,
      OP_SCAN_SETUP,
      OP_SCAN,
      OP_PUT_C,
      OP_SHIFT,
      OP_PUT_SENT,
      OP_FINISH
   } op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      JC_NEVER,
      JC_ALWAYS,
      JC_IDLE_STAY,
      JC_WAS_READ,
      JC_SHORT,
      JC_BUSY,
      JC_MORE
   } jc_type;

   // One control word
   typedef struct packed {
      op_type op;
      jc_type jc;
      pc_type target;
   } ucode_type;

   // Status flags from the datapath to the sequencer
   typedef struct packed {
      logic idle_stay;
      logic was_read;
      logic short_text;
      logic busy;
      logic more;
   } flags_type;

   // Control program
   function automatic ucode_type ucode_fetch(input pc_type pc);
      ucode_type w;
      w = '{op: OP_FINISH, jc: JC_ALWAYS, target: STEP_IDLE};
      unique case (pc)
         STEP_IDLE:       w = '{op: OP_ACCEPT,     jc: JC_IDLE_STAY, target: STEP_IDLE};
         STEP_DISPATCH:   w = '{op: OP_DISPATCH,   jc: JC_WAS_READ,  target: STEP_IDLE};
         STEP_SEAL:       w = '{op: OP_SEAL,       jc: JC_SHORT,     target: STEP_FINISH};
         STEP_FETCH:      w = '{op: OP_FETCH,      jc: JC_NEVER,     target: STEP_IDLE};
         STEP_SCAN_SETUP: w = '{op: OP_SCAN_SETUP, jc: JC_NEVER,     target: STEP_IDLE};
         STEP_SCAN:       w = '{op: OP_SCAN,       jc: JC_BUSY,      target: STEP_SCAN};
         STEP_PUT_C:      w = '{op: OP_PUT_C,      jc: JC_NEVER,     target: STEP_IDLE};
         STEP_SHIFT:      w = '{op: OP_SHIFT,      jc: JC_BUSY,      target: STEP_SHIFT};
         STEP_PUT_SENT:   w = '{op: OP_PUT_SENT,   jc: JC_MORE,      target: STEP_FETCH};
         STEP_FINISH:     w = '{op: OP_FINISH,     jc: JC_ALWAYS,    target: STEP_IDLE};
         default:         w = '{op: OP_FINISH,     jc: JC_ALWAYS,    target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/bwt_in_place_builder.sv */
// Top level of the in-place Burrows-Wheeler transform builder.
`default_nettype none

// Loads a text of nonzero bytes one item at a time (tuser 0), then builds its
// Burrows-Wheeler transform in place in a 4096 x 8 store once an item with
// tlast arrives; reads (tuser 1) return the transformed byte at an index, zero
// marking the sentinel. Every request gives one response. A plain load answers
// in the cycle after it is taken; a read answers from the dispatch step after
// the store read. The final load runs the transform: for each text position p,
// from the second-to-last symbol down, it fetches the symbol, counts the symbols
// that rank below it, writes it over the sentinel, shifts the span and puts the
// sentinel back. The store has a single read and a single write port and no
// clear after reset; only bytes inside the stored length are ever returned.
module bwt_in_place_builder import bwtb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // sym_in[7:0], read_index[19:8], zero[23:20]
   input  wire logic        req_tlast,  // end_of_text
   input  wire logic        req_tuser,  // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // sym_out[7:0], text_length[20:8], zero[23:21]
   output logic [1:0]       rsp_tuser   // status[1:0]
);

   ucode_type         uc;
   flags_type         flags;
   logic [SYM_W-1:0]  rsp_sym;
   logic [LEN_W-1:0]  rsp_len;

   bwtb_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uc    (uc)
   );

   bwtb_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .uc         (uc),
      .flags      (flags),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_tuser),
      .req_sym    (req_tdata[7:0]),
      .req_eot    (req_tlast),
      .req_index  (req_tdata[19:8]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_sym    (rsp_sym),
      .rsp_status (rsp_tuser),
      .rsp_len    (rsp_len)
   );

   // Pack the response item
   assign rsp_tdata = {3'b000, rsp_len, rsp_sym};

endmodule

`default_nettype wire

/* hw/rtl/bwtb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bwtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

/* hw/rtl/bwtb_sequencer.sv */
// Step counter and control-word fetch with conditional jumps.
`default_nettype none

module bwtb_sequencer import bwtb_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire flags_type flags,
   output ucode_type      uc
);

   pc_type pc_ff;
   pc_type pc_in;
   logic   take;

   assign uc = ucode_fetch(pc_ff);

   // Evaluate the jump condition of the current step
   always_comb begin
      unique case (uc.jc)
         JC_NEVER:     take = 1'b0;
         JC_ALWAYS:    take = 1'b1;
         JC_IDLE_STAY: take = flags.idle_stay;
         JC_WAS_READ:  take = flags.was_read;
         JC_SHORT:     take = flags.short_text;
         JC_BUSY:      take = flags.busy;
         JC_MORE:      take = flags.more;
         default:      take = 1'b1;
      endcase
      pc_in = take ? uc.target : pc_ff + pc_type'(1);
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/bwtb_datapath.sv */
// Datapath: text store, scan counter, shift pointers and response register.
`default_nettype none

module bwtb_datapath import bwtb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ucode_type         uc,
   output flags_type              flags,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_func,
   input  wire logic [SYM_W-1:0]  req_sym,
   input  wire logic              req_eot,
   input  wire logic [ADDR_W-1:0] req_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [SYM_W-1:0]       rsp_sym,
   output logic [1:0]             rsp_status,
   output logic [LEN_W-1:0]       rsp_len
);

   // Control state
   logic             done_ff, done_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic             rv_ff, rv_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] sp_ff, sp_in;
   logic [ADDR_W-1:0] wk_ff, wk_in;
   logic [LEN_W-1:0]  addr_ff, addr_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [SYM_W-1:0]  c_ff, c_in;
   logic              le_ff, le_in;
   logic              is_read_ff, is_read_in;
   logic [1:0]        status_ff, status_in;
   logic [SYM_W-1:0]  rsp_sym_ff, rsp_sym_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   // Store ports
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [SYM_W-1:0]  wdata;
   logic [ADDR_W-1:0] raddr;
   logic [SYM_W-1:0]  rdata;

   // Request decode
   logic             accept;
   logic [LEN_W-1:0] eff_count;
   logic             sym_ok;
   logic [1:0]       load_status;
   logic [LEN_W-1:0] new_count;
   logic             build;
   logic             rd_fail;
   logic [LEN_W-1:0] shift_last;
   logic             scan_issue;
   logic             shift_issue;
   logic             hit;

   bwtb_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign req_ready = (uc.op == OP_ACCEPT) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // A load after a finished transform starts a new text
   assign eff_count   = done_ff ? '0 : count_ff;
   assign sym_ok      = (req_sym != '0) && (eff_count < LEN_W'(MAX_LEN - 1));
   assign load_status = (req_sym == '0) ? ST_ZERO : (sym_ok ? ST_OK : ST_FULL);
   assign new_count   = eff_count + LEN_W'(sym_ok);
   assign build       = req_eot && (new_count != '0);
   assign rd_fail     = !done_ff || ({1'b0, req_index} >= count_ff);

   // Scan and shift bounds
   assign shift_last  = {1'b0, pos_ff} + cnt_ff;
   assign scan_issue  = addr_ff < count_ff;
   assign shift_issue = addr_ff <= shift_last;
   // Up to the sentinel count symbols <= c, after it symbols < c
   assign hit         = le_ff ? (rdata <= c_ff) : (rdata < c_ff);

   assign flags.idle_stay  = !accept || ((req_func == FUNC_LOAD) && !build);
   assign flags.was_read   = is_read_ff;
   assign flags.short_text = count_ff < LEN_W'(2);
   assign flags.busy       = (uc.op == OP_SCAN) ? scan_issue : shift_issue;
   assign flags.more       = pos_ff != '0;

   // Execute the operation of the current step
   always_comb begin
      done_in       = done_ff;
      count_in      = count_ff;
      rv_in         = rv_ff;
      pos_in        = pos_ff;
      sp_in         = sp_ff;
      wk_in         = wk_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      c_in          = c_ff;
      le_in         = le_ff;
      is_read_in    = is_read_ff;
      status_in     = status_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      we            = 1'b0;
      waddr         = '0;
      wdata         = '0;
      raddr         = '0;

      unique case (uc.op)
         OP_ACCEPT: begin
            if (accept) begin
               if (req_func == FUNC_READ) begin
                  raddr      = req_index;
                  is_read_in = 1'b1;
                  status_in  = rd_fail ? ST_RANGE : ST_OK;
               end else begin
                  is_read_in = 1'b0;
                  status_in  = load_status;
                  count_in   = new_count;
                  done_in    = 1'b0;
                  if (sym_ok) begin
                     we    = 1'b1;
                     waddr = eff_count[ADDR_W-1:0];
                     wdata = req_sym;
                  end
                  if (!build) begin
                     rsp_valid_in  = 1'b1;
                     rsp_sym_in    = '0;
                     rsp_status_in = load_status;
                     rsp_len_in    = new_count;
                  end
               end
            end
         end
         OP_DISPATCH: begin
            if (is_read_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = (status_ff == ST_OK) ? rdata : '0;
               rsp_status_in = status_ff;
               rsp_len_in    = count_ff;
            end
         end
         OP_SEAL: begin
            // Append the sentinel, start at the second-to-last symbol
            we       = 1'b1;
            waddr    = count_ff[ADDR_W-1:0];
            wdata    = '0;
            count_in = count_ff + LEN_W'(1);
            pos_in   = ADDR_W'(count_ff - LEN_W'(2));
            cnt_in   = LEN_W'(1);
         end
         OP_FETCH: begin
            raddr = pos_ff;
         end
         OP_SCAN_SETUP: begin
            c_in    = rdata;
            addr_in = {1'b0, pos_ff} + LEN_W'(1);
            sp_in   = ADDR_W'({1'b0, pos_ff} + LEN_W'(1) + cnt_ff);
            cnt_in  = '0;
            rv_in   = 1'b0;
         end
         OP_SCAN: begin
            if (scan_issue) begin
               raddr   = addr_ff[ADDR_W-1:0];
               addr_in = addr_ff + LEN_W'(1);
            end
            rv_in = scan_issue;
            le_in = addr_ff <= {1'b0, sp_ff};
            if (rv_ff && hit) begin
               cnt_in = cnt_ff + LEN_W'(1);
            end
         end
         OP_PUT_C: begin
            // Symbol overwrites the sentinel
            we      = 1'b1;
            waddr   = sp_ff;
            wdata   = c_ff;
            addr_in = {1'b0, pos_ff} + LEN_W'(1);
            wk_in   = pos_ff;
            rv_in   = 1'b0;
         end
         OP_SHIFT: begin
            // Read one ahead, write one behind
            if (shift_issue) begin
               raddr   = addr_ff[ADDR_W-1:0];
               addr_in = addr_ff + LEN_W'(1);
            end
            rv_in = shift_issue;
            if (rv_ff) begin
               we    = 1'b1;
               waddr = wk_ff;
               wdata = rdata;
               wk_in = wk_ff + ADDR_W'(1);
            end
         end
         OP_PUT_SENT: begin
            we    = 1'b1;
            waddr = shift_last[ADDR_W-1:0];
            wdata = '0;
            if (pos_ff != '0) begin
               pos_in = pos_ff - ADDR_W'(1);
            end
         end
         OP_FINISH: begin
            done_in       = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_sym_in    = '0;
            rsp_status_in = status_ff;
            rsp_len_in    = count_ff;
         end
         default: ;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 1'b0;
         count_ff     <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         count_ff     <= count_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      sp_ff         <= sp_in;
      wk_ff         <= wk_in;
      addr_ff       <= addr_in;
      cnt_ff        <= cnt_in;
      c_ff          <= c_in;
      le_ff         <= le_in;
      is_read_ff    <= is_read_in;
      status_ff     <= status_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sym    = rsp_sym_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_len    = rsp_len_ff;

endmodule

`default_nettype wire

/* hw/rtl/bwtb_checker.sv */
// Port-level assertions for the in-place BWT builder, bound to the top level.
`default_nettype none

module bwtb_checker import bwtb_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // A stalled response holds its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A taken read leaves the request port not ready in the cycle after
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == FUNC_READ) |=> !req_tready)
      else $error("request taken during read turnaround");

   // Any failing status carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata[7:0] == 8'd0)
      else $error("nonzero byte with failing status");

   // Reported length never exceeds the store
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[20:8] <= 13'(MAX_LEN)) && (rsp_tdata[23:21] == 3'd0))
      else $error("length out of range");

endmodule

bind bwt_in_place_builder bwtb_checker u_bwtb_checker (.*);

`default_nettype wire
